// ----- src/tree_ancestor_query_assert.svh -----
// ----------------------------------------------------------------------------
// tree ancestor query assertion macros
// shared property forms for the checker, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef TREE_ANCESTOR_QUERY_ASSERT_SVH
`define TREE_ANCESTOR_QUERY_ASSERT_SVH

// condition in this cycle implies another in the next cycle
`define TAQ_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

// condition in this cycle implies another in the same cycle
`define TAQ_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

`endif

// ----- src/taq_pkg.sv -----
// ----------------------------------------------------------------------------
// taq_pkg
// node id widths, table constants and control structs of the ancestor query
// ----------------------------------------------------------------------------
`default_nettype none

package taq_pkg;

    localparam int ID_W        = 18;
    localparam int TABLE_DEPTH = 2 ** ID_W;

    typedef logic [ID_W-1:0] node_id_t;

    localparam node_id_t ROOT_ID = node_id_t'(1);

    // query start from the top level to the walker
    typedef struct packed {
        logic     start;
        node_id_t node_a;
        node_id_t node_b;
    } walk_req_t;

    // walker status back to the top level
    typedef struct packed {
        logic busy;
        logic done;
        logic related;
    } walk_stat_t;

endpackage

`default_nettype wire

// ----- src/tree_ancestor_query.sv -----
// ----------------------------------------------------------------------------
// tree_ancestor_query
// ancestor test on a rooted tree kept as a parent table in ram
// ----------------------------------------------------------------------------
// An edge transfer (op 0) writes the parent node_a of child node_b, gives
// no result and leaves the block ready for the next transfer.
// A query transfer (op 1) climbs parent links from node_a toward node_b, then
// if needed from node_b toward node_a, and gives one related result. Each
// parent read is a ram read with registered data, then a compare. The parent
// reads of each walk are capped at NODES. in_stall stays high from a query
// transfer until its result is offered, which happens in the cycle in_stall
// drops; while a stalled earlier result still holds the output register,
// in_stall stays high until it leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module tree_ancestor_query #(
    parameter int NODES = 262144
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic              op,
    input  wire taq_pkg::node_id_t node_a,
    input  wire taq_pkg::node_id_t node_b,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic                   related
);

    import taq_pkg::*;

    walk_req_t  req;
    walk_stat_t stat;
    logic       in_take;
    logic       slot_free;
    logic       res_take;
    logic       rd_en;
    node_id_t   rd_addr;
    node_id_t   rd_data;
    logic       out_valid_reg;
    logic       related_reg;

    // input transfer and routing
    assign in_stall  = stat.busy;
    assign in_take   = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;
    assign res_take  = stat.done && slot_free;

    always_comb
    begin
        req.start  = in_take && op;
        req.node_a = node_a;
        req.node_b = node_b;
    end

    taq_ram #(
        .WIDTH (ID_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (in_take && !op),
        .waddr (node_b),
        .wdata (node_a),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    taq_walker #(
        .NODES (NODES)
    ) u_walker (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .res_take (res_take),
        .rd_data  (rd_data),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .stat     (stat)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (slot_free)
        begin
            out_valid_reg <= stat.done;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            related_reg <= stat.related;
        end
    end

    assign out_valid = out_valid_reg;
    assign related   = related_reg;

endmodule

`default_nettype wire

// ----- src/taq_ram.sv -----
// ----------------------------------------------------------------------------
// taq_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module taq_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 262144
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- src/taq_walker.sv -----
// ----------------------------------------------------------------------------
// taq_walker
// sequencer that climbs parent links with one compare unit and one ram read
// ----------------------------------------------------------------------------
`default_nettype none

module taq_walker #(
    parameter int NODES = 262144
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire taq_pkg::walk_req_t req,
    input  wire logic              res_take,
    input  wire taq_pkg::node_id_t rd_data,
    output logic                   rd_en,
    output taq_pkg::node_id_t      rd_addr,
    output taq_pkg::walk_stat_t    stat
);

    import taq_pkg::*;

    localparam int CNT_W = $clog2(NODES + 1);
    localparam logic [CNT_W-1:0] STEP_LIMIT = CNT_W'(NODES);

    typedef enum logic [1:0] {
        W_IDLE,
        W_CHECK,
        W_LOAD,
        W_DONE
    } walk_state_t;

    walk_state_t      state_reg;
    node_id_t         here_reg;
    node_id_t         target_reg;
    node_id_t         other_reg;
    node_id_t         first_reg;
    logic             phase_reg;
    logic [CNT_W-1:0] reads_reg;
    logic             related_reg;

    logic hit;
    logic stop;

    // shared compare unit on the current node
    always_comb
    begin
        hit  = (here_reg == target_reg);
        stop = (here_reg == ROOT_ID) || (reads_reg == STEP_LIMIT);
    end

    assign rd_en   = (state_reg == W_CHECK) && !hit && !stop;
    assign rd_addr = here_reg;

    // sequencer state and registered status
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= W_IDLE;
            here_reg    <= '0;
            target_reg  <= '0;
            other_reg   <= '0;
            first_reg   <= '0;
            phase_reg   <= 1'b0;
            reads_reg   <= '0;
            related_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                W_IDLE:
                begin
                    if (req.start)
                    begin
                        here_reg   <= req.node_a;
                        target_reg <= req.node_b;
                        other_reg  <= req.node_b;
                        first_reg  <= req.node_a;
                        phase_reg  <= 1'b0;
                        reads_reg  <= '0;
                        state_reg  <= W_CHECK;
                    end
                end
                W_CHECK:
                begin
                    priority if (hit)
                    begin
                        related_reg <= 1'b1;
                        state_reg   <= W_DONE;
                    end
                    else if (stop)
                    begin
                        // first walk failed: climb from the other node
                        if (!phase_reg)
                        begin
                            here_reg   <= other_reg;
                            target_reg <= first_reg;
                            phase_reg  <= 1'b1;
                            reads_reg  <= '0;
                        end
                        else
                        begin
                            related_reg <= 1'b0;
                            state_reg   <= W_DONE;
                        end
                    end
                    else
                    begin
                        state_reg <= W_LOAD;
                    end
                end
                W_LOAD:
                begin
                    here_reg  <= rd_data;
                    reads_reg <= reads_reg + CNT_W'(1);
                    state_reg <= W_CHECK;
                end
                W_DONE:
                begin
                    if (res_take)
                    begin
                        state_reg <= W_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= W_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        stat.busy    = (state_reg != W_IDLE);
        stat.done    = (state_reg == W_DONE);
        stat.related = related_reg;
    end

endmodule

`default_nettype wire

// ----- src/taq_checker.sv -----
// ----------------------------------------------------------------------------
// taq_checker
// port level checks of the ancestor query, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "tree_ancestor_query_assert.svh"

module taq_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_stall,
    input wire logic op,
    input wire logic out_valid,
    input wire logic out_stall,
    input wire logic related
);

    // stalled result holds
    `TAQ_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(related))

    // a query transfer makes the block busy
    `TAQ_ASSERT_NEXT(a_query_busy, in_valid && !in_stall && op, in_stall)

    // an edge transfer leaves the block ready
    `TAQ_ASSERT_NEXT(a_edge_ready, in_valid && !in_stall && !op, !in_stall)

    // a new result only comes out of a busy block
    `TAQ_ASSERT_NOW(a_result_busy, $rose(out_valid), $past(in_stall))

endmodule

bind tree_ancestor_query taq_checker u_taq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .related   (related)
);

`default_nettype wire

// ----- tb/tree_ancestor_query_tb.sv -----
// ----------------------------------------------------------------------------
// tree_ancestor_query_tb
// Drives edge and query transfers into the ancestor query block and checks
// every related result against a fixed answer or a bench parent table. A
// directed table covers id extremes, root and equal-node queries and a cycle
// that runs into the walk step limit. A random phase then grows and reshapes
// a well-formed tree and queries it. Both sides pause in random bursts.
// ----------------------------------------------------------------------------
`default_nettype none

module tree_ancestor_query_tb;

    import taq_pkg::*;

    localparam int WALK_LIMIT   = 262144;
    localparam int RANDOM_ITEMS = 600;
    localparam int QUIET_ITEMS  = 80;
    localparam int TAIL_CYCLES  = 40;
    localparam int CYCLE_LIMIT  = 4000000;
    localparam int SHOW_LIMIT   = 10;

    typedef enum logic {
        OP_EDGE  = 1'b0,
        OP_QUERY = 1'b1
    } op_e;

    // one row of the directed table
    typedef struct {
        op_e      kind;
        node_id_t a;
        node_id_t b;
        bit       fixed;
        bit       answer;
    } row_t;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     in_valid  = 1'b0;
    logic     in_stall;
    logic     op        = 1'b0;
    node_id_t node_a    = '0;
    node_id_t node_b    = '0;
    logic     out_valid;
    logic     out_stall = 1'b0;
    logic     related;

    // bench copy of the parent table and the set of nodes safe to walk from
    bit [ID_W-1:0] tree_parent [TABLE_DEPTH];
    bit            in_tree     [TABLE_DEPTH];
    node_id_t      members     [$];

    bit     related_due [$];
    int     fail_count  = 0;
    int     shown       = 0;
    int     cycle_count = 0;
    int     sent        = 0;
    bit     idle_ok     = 1'b1;
    bit     quiet       = 1'b0;

    tree_ancestor_query #(
        .NODES(WALK_LIMIT)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .op       (op),
        .node_a   (node_a),
        .node_b   (node_b),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .related  (related)
    );

    always #6 clk = ~clk;

    // climb parent links from one node until the root, the target or the limit
    function automatic bit reaches(node_id_t from, node_id_t target);
        node_id_t here;
        int       reads;
        here  = from;
        reads = 0;
        while (here != ROOT_ID && here != target)
        begin
            if (reads >= WALK_LIMIT)
                return 1'b0;
            here  = tree_parent[here];
            reads = reads + 1;
        end
        return here == target;
    endfunction

    function automatic bit predict_related(node_id_t a, node_id_t b);
        return reaches(a, b) || reaches(b, a);
    endfunction

    // a node of the tree, the root now and then
    function automatic node_id_t pick_node();
        if (members.size() == 0 || $urandom_range(0, 7) == 0)
            return ROOT_ID;
        return members[$urandom_range(0, members.size() - 1)];
    endfunction

    function automatic void add_member(node_id_t id);
        if (id != ROOT_ID && !in_tree[id])
        begin
            in_tree[id] = 1'b1;
            members.push_back(id);
        end
    endfunction

    // one input transfer; leaves the bench on the falling edge after it
    task automatic send_item(op_e kind, node_id_t a, node_id_t b, bit fixed, bit answer);
        in_valid <= 1'b1;
        op       <= kind;
        node_a   <= a;
        node_b   <= b;
        do
            @(posedge clk);
        while (in_stall);
        if (kind == OP_EDGE)
            tree_parent[b] = a;
        else
            related_due.push_back(fixed ? answer : predict_related(a, b));
        sent = sent + 1;
        @(negedge clk);
    endtask

    // sender gap of a random burst length
    task automatic maybe_idle();
        if (idle_ok && !quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
    endtask

    // result check against the oldest expectation
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (rst_n && out_valid && !out_stall)
        begin
            if (related_due.size() == 0)
            begin
                fail_count = fail_count + 1;
                if (shown < SHOW_LIMIT)
                begin
                    shown = shown + 1;
                    $display("unexpected result transfer: related=%0d", related);
                end
            end
            else
            begin
                bit want;
                want = related_due.pop_front();
                if (related !== want)
                begin
                    fail_count = fail_count + 1;
                    if (shown < SHOW_LIMIT)
                    begin
                        shown = shown + 1;
                        $display("related mismatch: expected %0d actual %0d", want, related);
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // receiver stall bursts
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                out_stall  <= 1'b1;
                stall_left = stall_left - 1;
            end
            else
            begin
                out_stall <= 1'b0;
                if (idle_ok && !quiet && $urandom_range(0, 9) == 0)
                    stall_left = $urandom_range(1, 15);
            end
        end
    end

    // stimulus
    initial
    begin
        row_t     rows [$];
        node_id_t a;
        node_id_t b;
        node_id_t x;
        int       pick;
        int       steps;
        bit       paused;

        paused = 1'b0;

        // directed rows: extremes, root and equal cases, step limit on a cycle
        rows.push_back('{OP_EDGE,  18'd1,      18'd2,      1'b0, 1'b0});
        rows.push_back('{OP_EDGE,  18'd2,      18'd262143, 1'b0, 1'b0});
        rows.push_back('{OP_EDGE,  18'd262143, 18'd0,      1'b0, 1'b0});
        rows.push_back('{OP_EDGE,  18'd0,      18'd3,      1'b0, 1'b0});
        rows.push_back('{OP_EDGE,  18'h2AAAA,  18'd1,      1'b0, 1'b0});
        rows.push_back('{OP_QUERY, 18'd1,      18'd1,      1'b1, 1'b1});
        rows.push_back('{OP_QUERY, 18'd262143, 18'd262143, 1'b1, 1'b1});
        rows.push_back('{OP_QUERY, 18'h15555,  18'h15555,  1'b1, 1'b1});
        rows.push_back('{OP_QUERY, 18'd1,      18'd3,      1'b1, 1'b1});
        rows.push_back('{OP_QUERY, 18'd3,      18'd2,      1'b1, 1'b1});
        rows.push_back('{OP_QUERY, 18'd0,      18'd262143, 1'b1, 1'b1});
        rows.push_back('{OP_EDGE,  18'd1,      18'd4,      1'b0, 1'b0});
        rows.push_back('{OP_QUERY, 18'd4,      18'd3,      1'b1, 1'b0});
        rows.push_back('{OP_QUERY, 18'd3,      18'd4,      1'b1, 1'b0});
        rows.push_back('{OP_QUERY, 18'd4,      18'd1,      1'b1, 1'b1});
        rows.push_back('{OP_EDGE,  18'd6,      18'd5,      1'b0, 1'b0});
        rows.push_back('{OP_EDGE,  18'd5,      18'd6,      1'b0, 1'b0});
        rows.push_back('{OP_QUERY, 18'd5,      18'd4,      1'b1, 1'b0});
        rows.push_back('{OP_EDGE,  18'd1,      18'd5,      1'b0, 1'b0});
        rows.push_back('{OP_QUERY, 18'd6,      18'd5,      1'b1, 1'b1});
        rows.push_back('{OP_QUERY, 18'd2,      18'd6,      1'b0, 1'b0});
        rows.push_back('{OP_EDGE,  18'd3,      18'd7,      1'b0, 1'b0});
        rows.push_back('{OP_QUERY, 18'd7,      18'd262143, 1'b0, 1'b0});
        rows.push_back('{OP_QUERY, 18'd262143, 18'd7,      1'b0, 1'b0});

        // reset
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table
        foreach (rows[i])
        begin
            maybe_idle();
            send_item(rows[i].kind, rows[i].a, rows[i].b, rows[i].fixed, rows[i].answer);
        end
        foreach (rows[i])
            if (rows[i].kind == OP_EDGE)
                add_member(rows[i].b);

        // random phase over a well-formed tree
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            idle_ok = ((sent / 50) % 3) != 2;
            quiet   = sent >= RANDOM_ITEMS - QUIET_ITEMS;
            maybe_idle();

            // sender holds off once until every result is back
            if (!paused && sent >= RANDOM_ITEMS / 2)
            begin
                paused   = 1'b1;
                in_valid <= 1'b0;
                while (related_due.size() != 0)
                    @(negedge clk);
                @(negedge clk);
            end

            pick = $urandom_range(0, 99);
            if (pick < 35)
            begin
                // new child under a tree node
                do
                    b = node_id_t'($urandom_range(0, TABLE_DEPTH - 1));
                while (in_tree[b] || b == ROOT_ID);
                a = pick_node();
                send_item(OP_EDGE, a, b, 1'b0, 1'b0);
                add_member(b);
            end
            else if (pick < 45 && members.size() != 0)
            begin
                // move a subtree, never below itself
                b = members[$urandom_range(0, members.size() - 1)];
                a = pick_node();
                x = a;
                while (x != ROOT_ID && x != b)
                    x = tree_parent[x];
                if (x == b)
                    a = ROOT_ID;
                send_item(OP_EDGE, a, b, 1'b0, 1'b0);
            end
            else if (pick < 50)
            begin
                // stray edge on a node outside the tree
                do
                    b = node_id_t'($urandom_range(0, TABLE_DEPTH - 1));
                while (in_tree[b]);
                a = node_id_t'($urandom_range(0, TABLE_DEPTH - 1));
                send_item(OP_EDGE, a, b, 1'b0, 1'b0);
            end
            else
            begin
                // query, half of them on an ancestor pair
                a = pick_node();
                if ($urandom_range(0, 1) == 1)
                begin
                    b     = a;
                    steps = $urandom_range(0, 6);
                    repeat (steps)
                        if (b != ROOT_ID)
                            b = tree_parent[b];
                end
                else
                    b = pick_node();
                if ($urandom_range(0, 1) == 1)
                begin
                    x = a;
                    a = b;
                    b = x;
                end
                send_item(OP_QUERY, a, b, 1'b0, 1'b0);
            end
        end

        // drain
        in_valid <= 1'b0;
        while (related_due.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (fail_count == 0 && related_due.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
